@@ hw/rtl/apt_pkg.sv @@
// ----------------------------------------------------------------------------
// apt_pkg: shared types and helpers for the box pose transform
// Beat types, register indexes, reset values and the saturating narrow.
// ----------------------------------------------------------------------------
package apt_pkg;

  localparam int COORD_W   = 32;
  localparam int QUAT_W    = 16;
  localparam int MAT_W     = 30;   // Q.24 matrix entry, range [-2^29, 2^29)
  localparam int CFG_W     = 64;
  localparam int CFG_IDX_W = 3;

  // register indexes on the write port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCALE_X  = 3'd0,
    REG_SCALE_Y  = 3'd1,
    REG_SCALE_Z  = 3'd2,
    REG_ROT_QUAT = 3'd3,
    REG_OFFSET_X = 3'd4,
    REG_OFFSET_Y = 3'd5,
    REG_OFFSET_Z = 3'd6
  } reg_index_t;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [MAT_W-1:0]   mat_entry_t;

  // reset values: unit scale, identity rotation, no translation
  localparam coord_t           SCALE_RESET  = 32'sd65536;
  localparam logic [CFG_W-1:0] QUAT_RESET   = 64'h4000_0000_0000_0000;
  localparam coord_t           OFFSET_RESET = 32'sd0;

  // input beat
  typedef struct packed {
    coord_t lo_x;
    coord_t lo_y;
    coord_t lo_z;
    coord_t hi_x;
    coord_t hi_y;
    coord_t hi_z;
  } box_t;

  // result beat
  typedef struct packed {
    coord_t new_lo_x;
    coord_t new_lo_y;
    coord_t new_lo_z;
    coord_t new_hi_x;
    coord_t new_hi_y;
    coord_t new_hi_z;
  } result_t;

  // pose as seen by the datapath: mat[i][j] weighs input axis j into output axis i
  typedef struct packed {
    mat_entry_t [2:0][2:0] mat;
    coord_t     [2:0]      scale;
    coord_t     [2:0]      offset;
  } pose_t;

  // clamp a 64 bit signed value to 32 bit signed
  function automatic coord_t sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'sh7fff_ffff;
    end else if (v < -64'sd2147483648) begin
      return 32'sh8000_0000;
    end else begin
      return v[COORD_W-1:0];
    end
  endfunction

endpackage

@@ hw/rtl/apt_pose.sv @@
// ----------------------------------------------------------------------------
// apt_pose: pose registers and rotation matrix
// Holds scale, quaternion and offset; builds the Q.24 matrix in two stages.
// ----------------------------------------------------------------------------
module apt_pose (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           write_en,
  input  logic [apt_pkg::CFG_IDX_W-1:0]  write_index,
  input  logic [apt_pkg::CFG_W-1:0]      write_data,
  output apt_pkg::pose_t                 pose
);

  localparam logic signed [33:0] ONE28 = 34'sd268435456;

  apt_pkg::coord_t           scale_x, scale_y, scale_z;
  apt_pkg::coord_t           offset_x, offset_y, offset_z;
  logic [apt_pkg::CFG_W-1:0] quat;

  logic signed [apt_pkg::QUAT_W-1:0] qw, qx, qy, qz;
  logic signed [31:0] xx, yy, zz, xy, xz, yz, wx, wy, wz;
  logic signed [33:0] r28 [3][3];
  apt_pkg::mat_entry_t [2:0][2:0] mat;

  // round half up from Q.28 to Q.24
  function automatic apt_pkg::mat_entry_t to_q24(input logic signed [33:0] v);
    logic signed [33:0] t;
    t = v + 34'sd8;
    return t[33:4];
  endfunction

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      scale_x  <= apt_pkg::SCALE_RESET;
      scale_y  <= apt_pkg::SCALE_RESET;
      scale_z  <= apt_pkg::SCALE_RESET;
      quat     <= apt_pkg::QUAT_RESET;
      offset_x <= apt_pkg::OFFSET_RESET;
      offset_y <= apt_pkg::OFFSET_RESET;
      offset_z <= apt_pkg::OFFSET_RESET;
    end else if (write_en) begin
      case (write_index)
        apt_pkg::REG_SCALE_X:  scale_x  <= write_data[apt_pkg::COORD_W-1:0];
        apt_pkg::REG_SCALE_Y:  scale_y  <= write_data[apt_pkg::COORD_W-1:0];
        apt_pkg::REG_SCALE_Z:  scale_z  <= write_data[apt_pkg::COORD_W-1:0];
        apt_pkg::REG_ROT_QUAT: quat     <= write_data;
        apt_pkg::REG_OFFSET_X: offset_x <= write_data[apt_pkg::COORD_W-1:0];
        apt_pkg::REG_OFFSET_Y: offset_y <= write_data[apt_pkg::COORD_W-1:0];
        apt_pkg::REG_OFFSET_Z: offset_z <= write_data[apt_pkg::COORD_W-1:0];
        default: ;
      endcase
    end
  end

  assign qw = quat[63:48];
  assign qx = quat[47:32];
  assign qy = quat[31:16];
  assign qz = quat[15:0];

  // quaternion cross products
  always_ff @(posedge clk) begin
    xx <= qx * qx;
    yy <= qy * qy;
    zz <= qz * qz;
    xy <= qx * qy;
    xz <= qx * qz;
    yz <= qy * qz;
    wx <= qw * qx;
    wy <= qw * qy;
    wz <= qw * qz;
  end

  // matrix entries at Q.28
  always_comb begin
    r28[0][0] = ONE28 - ((34'(yy) + 34'(zz)) <<< 1);
    r28[0][1] = (34'(xy) - 34'(wz)) <<< 1;
    r28[0][2] = (34'(xz) + 34'(wy)) <<< 1;
    r28[1][0] = (34'(xy) + 34'(wz)) <<< 1;
    r28[1][1] = ONE28 - ((34'(xx) + 34'(zz)) <<< 1);
    r28[1][2] = (34'(yz) - 34'(wx)) <<< 1;
    r28[2][0] = (34'(xz) - 34'(wy)) <<< 1;
    r28[2][1] = (34'(yz) + 34'(wx)) <<< 1;
    r28[2][2] = ONE28 - ((34'(xx) + 34'(yy)) <<< 1);
  end

  // rounded matrix register
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        mat[i][j] <= to_q24(r28[i][j]);
      end
    end
  end

  assign pose.mat       = mat;
  assign pose.scale[0]  = scale_x;
  assign pose.scale[1]  = scale_y;
  assign pose.scale[2]  = scale_z;
  assign pose.offset[0] = offset_x;
  assign pose.offset[1] = offset_y;
  assign pose.offset[2] = offset_z;

endmodule

@@ hw/rtl/apt_scale.sv @@
// ----------------------------------------------------------------------------
// apt_scale: per-axis scaling of both corners
// Stage one multiplies, stage two rounds half up and saturates to Q16.16.
// ----------------------------------------------------------------------------
module apt_scale (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  apt_pkg::box_t               box,
  input  apt_pkg::coord_t [2:0]       scale,
  output logic                        out_valid,
  output apt_pkg::coord_t [2:0]       lo,
  output apt_pkg::coord_t [2:0]       hi
);

  apt_pkg::coord_t [2:0] lo_in, hi_in;
  logic signed [63:0]    prod_lo [3];
  logic signed [63:0]    prod_hi [3];
  logic signed [63:0]    rnd_lo  [3];
  logic signed [63:0]    rnd_hi  [3];
  logic                  v1;

  assign lo_in[0] = box.lo_x;
  assign lo_in[1] = box.lo_y;
  assign lo_in[2] = box.lo_z;
  assign hi_in[0] = box.hi_x;
  assign hi_in[1] = box.hi_y;
  assign hi_in[2] = box.hi_z;

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1        <= in_valid;
      out_valid <= v1;
    end
  end

  // exact products at Q32
  always_ff @(posedge clk) begin
    for (int j = 0; j < 3; j++) begin
      prod_lo[j] <= $signed(scale[j]) * $signed(lo_in[j]);
      prod_hi[j] <= $signed(scale[j]) * $signed(hi_in[j]);
    end
  end

  // round half up, floor shift
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      rnd_lo[j] = (prod_lo[j] + 64'sd32768) >>> 16;
      rnd_hi[j] = (prod_hi[j] + 64'sd32768) >>> 16;
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < 3; j++) begin
      lo[j] <= apt_pkg::sat32(rnd_lo[j]);
      hi[j] <= apt_pkg::sat32(rnd_hi[j]);
    end
  end

endmodule

@@ hw/rtl/apt_bound.sv @@
// ----------------------------------------------------------------------------
// apt_bound: rotate, order and sum into the bounding box
// Four stages: matrix products, min/max ordering, sums, round and saturate.
// ----------------------------------------------------------------------------
module apt_bound (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  apt_pkg::coord_t [2:0]  lo,
  input  apt_pkg::coord_t [2:0]  hi,
  input  apt_pkg::pose_t         pose,
  output logic                   out_valid,
  output apt_pkg::result_t       result
);

  localparam int PROD_W = apt_pkg::MAT_W + apt_pkg::COORD_W;

  logic signed [PROD_W-1:0] prod_a [3][3];
  logic signed [PROD_W-1:0] prod_b [3][3];
  logic signed [PROD_W-1:0] pmin   [3][3];
  logic signed [PROD_W-1:0] pmax   [3][3];
  logic signed [63:0]       base   [3];
  logic signed [63:0]       sum_lo [3];
  logic signed [63:0]       sum_hi [3];
  logic signed [63:0]       rnd_lo [3];
  logic signed [63:0]       rnd_hi [3];
  apt_pkg::coord_t [2:0]    out_lo, out_hi;
  logic                     v3, v4, v5;

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v3        <= 1'b0;
      v4        <= 1'b0;
      v5        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v3        <= in_valid;
      v4        <= v3;
      v5        <= v4;
      out_valid <= v5;
    end
  end

  // matrix times scaled corners, exact at Q.40
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        prod_a[i][j] <= $signed(pose.mat[i][j]) * $signed(lo[j]);
        prod_b[i][j] <= $signed(pose.mat[i][j]) * $signed(hi[j]);
      end
    end
  end

  // order each product pair
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        if (prod_a[i][j] < prod_b[i][j]) begin
          pmin[i][j] <= prod_a[i][j];
          pmax[i][j] <= prod_b[i][j];
        end else begin
          pmin[i][j] <= prod_b[i][j];
          pmax[i][j] <= prod_a[i][j];
        end
      end
    end
  end

  // translation at Q.40
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      base[i] = 64'($signed(pose.offset[i])) <<< 24;
    end
  end

  // lower and upper sums
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      sum_lo[i] <= base[i] + 64'(pmin[i][0]) + 64'(pmin[i][1]) + 64'(pmin[i][2]);
      sum_hi[i] <= base[i] + 64'(pmax[i][0]) + 64'(pmax[i][1]) + 64'(pmax[i][2]);
    end
  end

  // round half up to Q16.16
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rnd_lo[i] = (sum_lo[i] + 64'sd8388608) >>> 24;
      rnd_hi[i] = (sum_hi[i] + 64'sd8388608) >>> 24;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      out_lo[i] <= apt_pkg::sat32(rnd_lo[i]);
      out_hi[i] <= apt_pkg::sat32(rnd_hi[i]);
    end
  end

  assign result.new_lo_x = out_lo[0];
  assign result.new_lo_y = out_lo[1];
  assign result.new_lo_z = out_lo[2];
  assign result.new_hi_x = out_hi[0];
  assign result.new_hi_y = out_hi[1];
  assign result.new_hi_z = out_hi[2];

endmodule

@@ hw/rtl/aabb_pose_transform.sv @@
// ----------------------------------------------------------------------------
// aabb_pose_transform: bounding box of a box under a scaled pose
// Scales, rotates and translates an axis-aligned box, returns its bounds.
// ----------------------------------------------------------------------------
// Usage:
//   Input beat: drive box and raise start; the beat is taken at a rising
//   edge with start high and busy low. busy is low in every cycle except
//   the first one after reset, so one box can be taken every cycle.
//   Result beat: done is high for one cycle with result valid; it is taken
//   at the edge that ends that cycle. The receiver cannot stall, and the
//   pipeline has no stall path: results leave in input order.
//   Path: a box taken at an edge passes the scale multiply, scale round,
//   matrix multiply, min/max order, sums and final round registers, then
//   shows done. Throughput: one box per cycle, set by the fully pipelined
//   multipliers of each stage.
//   Configuration: write_en, write_index, write_data; a write lands at the
//   edge with write_en high, indexes above the list are dropped. Write only
//   while no box is in flight; the rotation matrix follows the quaternion
//   register via the cross-product registers, before any new box reaches it.
//   Reset: synchronous, clears the pipeline and loads the identity pose.
// ----------------------------------------------------------------------------
module aabb_pose_transform (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  apt_pkg::box_t                  box,
  output logic                           done,
  output apt_pkg::result_t               result,
  input  logic                           write_en,
  input  logic [apt_pkg::CFG_IDX_W-1:0]  write_index,
  input  logic [apt_pkg::CFG_W-1:0]      write_data
);

  apt_pkg::pose_t        pose;
  apt_pkg::coord_t [2:0] scaled_lo, scaled_hi;
  logic                  scaled_valid;
  logic                  accept;

  // held off only in the cycle after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
    end else begin
      busy <= 1'b0;
    end
  end

  assign accept = start & ~busy;

  apt_pose u_pose (
    .clk         (clk),
    .rst         (rst),
    .write_en    (write_en),
    .write_index (write_index),
    .write_data  (write_data),
    .pose        (pose)
  );

  apt_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept),
    .box       (box),
    .scale     (pose.scale),
    .out_valid (scaled_valid),
    .lo        (scaled_lo),
    .hi        (scaled_hi)
  );

  apt_bound u_bound (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (scaled_valid),
    .lo        (scaled_lo),
    .hi        (scaled_hi),
    .pose      (pose),
    .out_valid (done),
    .result    (result)
  );

endmodule

@@ hw/rtl/apt_checker.sv @@
// ----------------------------------------------------------------------------
// apt_checker: port-level checks for the box pose transform
// Latency, beat accounting and ordering of the result corners.
// ----------------------------------------------------------------------------
module apt_checker (
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input logic             done,
  input apt_pkg::result_t result
);

  // ready again right after reset
  a_busy_release: assert property (@(posedge clk) !rst |=> !busy)
    else $error("busy still high after reset released");

  // every accepted beat produces a result on done
  a_beat_out: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##6 done)
    else $error("accepted beat did not produce a result");

  // no result without an accepted beat
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 6))
    else $error("result without an accepted beat");

  // lower corner never above upper corner
  a_corner_order: assert property (@(posedge clk) disable iff (rst)
    done |-> ($signed(result.new_lo_x) <= $signed(result.new_hi_x)) &&
             ($signed(result.new_lo_y) <= $signed(result.new_hi_y)) &&
             ($signed(result.new_lo_z) <= $signed(result.new_hi_z)))
    else $error("result corners out of order");

endmodule

bind aabb_pose_transform apt_checker u_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);
